/* rtl/core/gptm_pkg.sv */
package gptm_pkg;

  // Field and register widths
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned CFG_W   = 16;

  // Largest usable view size and texture dimension
  localparam int unsigned MAX_VIEW_SIZE = 4096;
  localparam int unsigned MAX_TEX_DIM   = 4096;

  // Internal datapath widths
  localparam int unsigned OFS_W   = 15;   // half-pixel offset from disc center
  localparam int unsigned SQ_W    = 28;   // squared offsets
  localparam int unsigned DISC_W  = 29;   // disc test value, signed
  localparam int unsigned PT_W    = 18;   // point in 1/32 pixel units
  localparam int unsigned RAD_W   = 34;   // radicand of square roots
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned P1_W    = Q_W + PT_W;
  localparam int unsigned T_W     = P1_W + 2;
  localparam int unsigned P2_W    = T_W + Q_W;
  localparam int unsigned U_W     = P2_W + 2;
  localparam int unsigned ROUND_SHIFT = 28;
  localparam int unsigned ROT_W   = U_W - ROUND_SHIFT;
  localparam int unsigned YSQ_W   = 2 * ROT_W;
  localparam int unsigned ANG_W   = 26;
  localparam int unsigned PROD_W  = ANG_W + DIM_W + 1;

  // Angle units are 2^-24 turn
  localparam int unsigned CORDIC_STEPS = 22;
  localparam int unsigned CORDIC_W     = 36;
  localparam int unsigned ATAN_W       = 22;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(8388608);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(4194304);
  localparam logic signed [U_W-1:0]   ROUND_HALF   = U_W'(1) << (ROUND_SHIFT - 1);

  localparam logic [ATAN_W-1:0] ATAN_LUT [CORDIC_STEPS] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
    22'd41718,   22'd20860,   22'd10430,  22'd5215,   22'd2608,   22'd1304,
    22'd652,     22'd326,     22'd163,    22'd81,     22'd41,     22'd20,
    22'd10,      22'd5,       22'd3,      22'd1
  };

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_IMAGE_SIZE = 3'd0,
    REG_ROT_W      = 3'd1,
    REG_ROT_I      = 3'd2,
    REG_ROT_J      = 3'd3,
    REG_ROT_K      = 3'd4,
    REG_TEX_COLS   = 3'd5,
    REG_TEX_ROWS   = 3'd6
  } cfg_idx_e;

endpackage

/* rtl/core/gptm_sqrt_pipe.sv */
module gptm_sqrt_pipe #(
  parameter int unsigned IN_W   = 34,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned OUT_W = IN_W / 2;
  localparam int unsigned REM_W = OUT_W + 2;

  logic [OUT_W-1:0]  v_q;
  logic [IN_W-1:0]   rad_q  [OUT_W];
  logic [REM_W-1:0]  rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  // One result bit per stage, two radicand bits consumed
  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [IN_W-1:0]   rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [OUT_W-1:0]  root_p;
    logic [SIDE_W-1:0] side_p;
    logic              v_p;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
      assign v_p    = valid_i;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
      assign v_p    = v_q[k-1];
    end

    assign rem_sh = {rem_p[OUT_W-1:0], rad_p[IN_W-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_p << 2;
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_p[OUT_W-2:0], ge};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = v_q[OUT_W-1];
  assign root_o  = root_q[OUT_W-1];
  assign side_o  = side_q[OUT_W-1];

endmodule

/* rtl/core/gptm_rotate.sv */
module gptm_rotate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               on_i,
  input  logic signed [gptm_pkg::PT_W-1:0]   x_i,
  input  logic signed [gptm_pkg::PT_W-1:0]   y_i,
  input  logic signed [gptm_pkg::PT_W-1:0]   z_i,
  input  logic signed [gptm_pkg::Q_W-1:0]    q_w_i,
  input  logic signed [gptm_pkg::Q_W-1:0]    q_i_i,
  input  logic signed [gptm_pkg::Q_W-1:0]    q_j_i,
  input  logic signed [gptm_pkg::Q_W-1:0]    q_k_i,
  output logic                               valid_o,
  output logic                               on_o,
  output logic signed [gptm_pkg::ROT_W-1:0]  xr_o,
  output logic signed [gptm_pkg::ROT_W-1:0]  yr_o,
  output logic signed [gptm_pkg::ROT_W-1:0]  zr_o
);

  import gptm_pkg::*;

  logic [3:0] v_q;
  logic [3:0] on_q;

  logic signed [P1_W-1:0] pa_d [12];
  logic signed [P1_W-1:0] pa_q [12];
  logic signed [T_W-1:0]  t_d  [4];
  logic signed [T_W-1:0]  t_q  [4];
  logic signed [P2_W-1:0] pb_d [12];
  logic signed [P2_W-1:0] pb_q [12];
  logic signed [U_W-1:0]  u1, u2, u3;
  logic signed [U_W-1:0]  u1_r, u2_r, u3_r;
  logic signed [ROT_W-1:0] xr_q, yr_q, zr_q;

  // First product q * p, with p = (0, x, y, z)
  always_comb begin
    pa_d[0]  = q_i_i * x_i;
    pa_d[1]  = q_j_i * y_i;
    pa_d[2]  = q_k_i * z_i;
    pa_d[3]  = q_w_i * x_i;
    pa_d[4]  = q_j_i * z_i;
    pa_d[5]  = q_k_i * y_i;
    pa_d[6]  = q_w_i * y_i;
    pa_d[7]  = q_i_i * z_i;
    pa_d[8]  = q_k_i * x_i;
    pa_d[9]  = q_w_i * z_i;
    pa_d[10] = q_i_i * y_i;
    pa_d[11] = q_j_i * x_i;
  end

  always_comb begin
    t_d[0] = -(T_W'(pa_q[0]) + T_W'(pa_q[1]) + T_W'(pa_q[2]));
    t_d[1] = T_W'(pa_q[3]) + T_W'(pa_q[4]) - T_W'(pa_q[5]);
    t_d[2] = T_W'(pa_q[6]) - T_W'(pa_q[7]) + T_W'(pa_q[8]);
    t_d[3] = T_W'(pa_q[9]) + T_W'(pa_q[10]) - T_W'(pa_q[11]);
  end

  // Second product t * conj(q)
  always_comb begin
    pb_d[0]  = t_q[1] * q_w_i;
    pb_d[1]  = t_q[0] * q_i_i;
    pb_d[2]  = t_q[2] * q_k_i;
    pb_d[3]  = t_q[3] * q_j_i;
    pb_d[4]  = t_q[0] * q_j_i;
    pb_d[5]  = t_q[1] * q_k_i;
    pb_d[6]  = t_q[2] * q_w_i;
    pb_d[7]  = t_q[3] * q_i_i;
    pb_d[8]  = t_q[0] * q_k_i;
    pb_d[9]  = t_q[1] * q_j_i;
    pb_d[10] = t_q[2] * q_i_i;
    pb_d[11] = t_q[3] * q_w_i;
  end

  // Sum and round half up back to 1/32 pixel units
  always_comb begin
    u1 = U_W'(pb_q[0]) - U_W'(pb_q[1]) - U_W'(pb_q[2]) + U_W'(pb_q[3]);
    u2 = -U_W'(pb_q[4]) + U_W'(pb_q[5]) + U_W'(pb_q[6]) - U_W'(pb_q[7]);
    u3 = -U_W'(pb_q[8]) - U_W'(pb_q[9]) + U_W'(pb_q[10]) + U_W'(pb_q[11]);
    u1_r = u1 + ROUND_HALF;
    u2_r = u2 + ROUND_HALF;
    u3_r = u3 + ROUND_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      on_q <= {on_q[2:0], on_i};
      pa_q <= pa_d;
      t_q  <= t_d;
      pb_q <= pb_d;
      xr_q <= u1_r[U_W-1:ROUND_SHIFT];
      yr_q <= u2_r[U_W-1:ROUND_SHIFT];
      zr_q <= u3_r[U_W-1:ROUND_SHIFT];
    end
  end

  assign valid_o = v_q[3];
  assign on_o    = on_q[3];
  assign xr_o    = xr_q;
  assign yr_o    = yr_q;
  assign zr_o    = zr_q;

endmodule

/* rtl/core/gptm_cordic_pipe.sv */
module gptm_cordic_pipe #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [gptm_pkg::ROT_W-1:0]  y_i,
  input  logic signed [gptm_pkg::ROT_W-1:0]  x_i,
  input  logic [SIDE_W-1:0]                  side_i,
  output logic                               valid_o,
  output logic signed [gptm_pkg::ANG_W-1:0]  ang_o,
  output logic [SIDE_W-1:0]                  side_o
);

  import gptm_pkg::*;

  localparam int unsigned NS = CORDIC_STEPS + 1;

  logic [NS:0]                  v_q;
  logic signed [CORDIC_W-1:0]   x_q    [NS];
  logic signed [CORDIC_W-1:0]   y_q    [NS];
  logic signed [ANG_W-1:0]      z_q    [NS];
  logic                         zero_q [NS];
  logic [SIDE_W-1:0]            side_q [NS];
  logic signed [ANG_W-1:0]      ang_q;
  logic [SIDE_W-1:0]            side_out_q;

  logic                         zero_d;
  logic                         neg_d;
  logic signed [ROT_W-1:0]      xa, ya;
  logic signed [CORDIC_W-1:0]   xe, ye;
  logic signed [ANG_W-1:0]      base_d;

  // Fold the left half plane onto the right, scale up
  always_comb begin
    zero_d = (x_i == '0) && (y_i == '0);
    neg_d  = x_i[ROT_W-1];
    xa     = neg_d ? -x_i : x_i;
    ya     = neg_d ? -y_i : y_i;
    xe     = CORDIC_W'(xa);
    ye     = CORDIC_W'(ya);
    base_d = '0;
    if (neg_d) begin
      base_d = y_i[ROT_W-1] ? -HALF_TURN : HALF_TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= {xe[CORDIC_W-9:0], 8'b0};
      y_q[0]    <= {ye[CORDIC_W-9:0], 8'b0};
      z_q[0]    <= base_d;
      zero_q[0] <= zero_d;
      side_q[0] <= side_i;
    end
  end

  // One vectoring micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]    at;
    logic                       pos;

    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign at  = $signed({{(ANG_W - ATAN_W){1'b0}}, ATAN_LUT[i]});
    assign pos = !y_q[i][CORDIC_W-1] && (y_q[i] != '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= pos ? (x_q[i] + ys) : (x_q[i] - ys);
        y_q[i+1]    <= pos ? (y_q[i] - xs) : (y_q[i] + xs);
        z_q[i+1]    <= pos ? (z_q[i] + at) : (z_q[i] - at);
        zero_q[i+1] <= zero_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Zero vector gives angle zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q      <= zero_q[NS-1] ? '0 : z_q[NS-1];
      side_out_q <= side_q[NS-1];
    end
  end

  assign valid_o = v_q[NS];
  assign ang_o   = ang_q;
  assign side_o  = side_out_q;

endmodule

/* rtl/core/globe_pixel_to_texture_map.sv */
// Channel   Signals                                        Direction
// input     in_valid_i, in_stall_o, pixel_x_i, pixel_y_i   into block
// output    out_valid_o, out_stall_i, on_globe_o,
//           tex_col_o, tex_row_o                           out of block
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i               into block, write only
//
// One item enters per clock while the output is not held; each result passes through
// the two 17-stage square roots and the 24-stage angle units.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A stalled output holds the whole pipeline, bubbles included, and drives in_stall_o.
module globe_pixel_to_texture_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gptm_pkg::PIX_W-1:0]      pixel_x_i,
  input  logic [gptm_pkg::PIX_W-1:0]      pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            on_globe_o,
  output logic [gptm_pkg::PIX_W-1:0]      tex_col_o,
  output logic [gptm_pkg::PIX_W-1:0]      tex_row_o,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [gptm_pkg::CFG_W-1:0]      cfg_wdata_i
);

  import gptm_pkg::*;

  localparam int unsigned ZSIDE_W = 1 + 2 * PT_W;
  localparam int unsigned LSIDE_W = 3 + 3 * ROT_W;

  logic en;

  // Configuration registers
  logic [DIM_W-1:0]      image_size_q, tex_cols_q, tex_rows_q;
  logic signed [Q_W-1:0] rot_w_q, rot_i_q, rot_j_q, rot_k_q;
  logic [DIM_W-1:0]      size_c, cols_c, rows_c;
  logic [PIX_W-1:0]      radius;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= DIM_W'(512);
      rot_w_q      <= Q_W'(16384);
      rot_i_q      <= '0;
      rot_j_q      <= '0;
      rot_k_q      <= '0;
      tex_cols_q   <= DIM_W'(2048);
      tex_rows_q   <= DIM_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_IMAGE_SIZE: image_size_q <= cfg_wdata_i[DIM_W-1:0];
        REG_ROT_W:      rot_w_q      <= cfg_wdata_i;
        REG_ROT_I:      rot_i_q      <= cfg_wdata_i;
        REG_ROT_J:      rot_j_q      <= cfg_wdata_i;
        REG_ROT_K:      rot_k_q      <= cfg_wdata_i;
        REG_TEX_COLS:   tex_cols_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_TEX_ROWS:   tex_rows_q   <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit dimensions to the supported maximum
  assign size_c = (32'(image_size_q) > MAX_VIEW_SIZE) ? DIM_W'(MAX_VIEW_SIZE) : image_size_q;
  assign cols_c = (32'(tex_cols_q) > MAX_TEX_DIM) ? DIM_W'(MAX_TEX_DIM) : tex_cols_q;
  assign rows_c = (32'(tex_rows_q) > MAX_TEX_DIM) ? DIM_W'(MAX_TEX_DIM) : tex_rows_q;
  assign radius = size_c[DIM_W-1:1];

  // Advance everything unless the output item is held
  logic out_v_q;
  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: half-pixel offsets from the disc center
  logic                    s1_v_q;
  logic signed [OFS_W-1:0] s1_x2_q, s1_y2_q;
  logic signed [OFS_W-1:0] x2_d, y2_d;

  always_comb begin
    x2_d = $signed({2'b00, pixel_x_i, 1'b1}) - $signed({2'b00, radius, 1'b0});
    y2_d = $signed({2'b00, pixel_y_i, 1'b1}) - $signed({2'b00, radius, 1'b0});
  end

  // Stage 2: squares
  logic                    s2_v_q;
  logic signed [OFS_W-1:0] s2_x2_q, s2_y2_q;
  logic [SQ_W-1:0]         s2_x2sq_q, s2_y2sq_q, s2_r4sq_q;
  logic signed [2*OFS_W-1:0] x2sq, y2sq;
  logic [2*PIX_W-1:0]      rsq;

  always_comb begin
    x2sq = s1_x2_q * s1_x2_q;
    y2sq = s1_y2_q * s1_y2_q;
    rsq  = radius * radius;
  end

  // Stage 3: disc test, front-point radicand
  logic                    s3_v_q, s3_on_q;
  logic [RAD_W-1:0]        s3_rad_q;
  logic signed [PT_W-1:0]  s3_x_q, s3_y_q;
  logic signed [DISC_W-1:0] disc;

  always_comb begin
    disc = $signed({1'b0, s2_r4sq_q}) - $signed({1'b0, s2_x2sq_q})
         - $signed({1'b0, s2_y2sq_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x2_q   <= x2_d;
      s1_y2_q   <= y2_d;
      s2_x2_q   <= s1_x2_q;
      s2_y2_q   <= s1_y2_q;
      s2_x2sq_q <= x2sq[SQ_W-1:0];
      s2_y2sq_q <= y2sq[SQ_W-1:0];
      s2_r4sq_q <= SQ_W'({rsq, 2'b00});
      s3_on_q   <= !disc[DISC_W-1];
      s3_rad_q  <= disc[DISC_W-1] ? '0 : {disc[RAD_W-9:0], 8'b0};
      s3_x_q    <= PT_W'({s2_x2_q, 4'b0000});
      s3_y_q    <= PT_W'({s2_y2_q, 4'b0000});
    end
  end

  // Depth of the front point
  logic                    zs_v;
  logic [ROOT_W-1:0]       zs_root;
  logic [ZSIDE_W-1:0]      zs_side;
  logic                    rt_on_in;
  logic signed [PT_W-1:0]  rt_x_in, rt_y_in, rt_z_in;

  gptm_sqrt_pipe #(
    .IN_W   (RAD_W),
    .SIDE_W (ZSIDE_W)
  ) u_zsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .rad_i   (s3_rad_q),
    .side_i  ({s3_on_q, s3_x_q, s3_y_q}),
    .valid_o (zs_v),
    .root_o  (zs_root),
    .side_o  (zs_side)
  );

  assign {rt_on_in, rt_x_in, rt_y_in} = zs_side;
  assign rt_z_in = -$signed({1'b0, zs_root});

  // Rotate by the configured quaternion
  logic                    rt_v, rt_on;
  logic signed [ROT_W-1:0] rt_xr, rt_yr, rt_zr;

  gptm_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (zs_v),
    .on_i    (rt_on_in),
    .x_i     (rt_x_in),
    .y_i     (rt_y_in),
    .z_i     (rt_z_in),
    .q_w_i   (rot_w_q),
    .q_i_i   (rot_i_q),
    .q_j_i   (rot_j_q),
    .q_k_i   (rot_k_q),
    .valid_o (rt_v),
    .on_o    (rt_on),
    .xr_o    (rt_xr),
    .yr_o    (rt_yr),
    .zr_o    (rt_zr)
  );

  // Latitude stage 1: squares of y and the sphere radius
  logic                    l1_v_q, l1_on_q;
  logic signed [ROT_W-1:0] l1_xr_q, l1_yr_q, l1_zr_q;
  logic [YSQ_W-1:0]        l1_yrsq_q;
  logic [RAD_W-1:0]        l1_rssq_q;
  logic signed [YSQ_W-1:0] yrsq;
  logic [ROOT_W-1:0]       rs;
  logic [RAD_W-1:0]        rssq;

  always_comb begin
    yrsq = rt_yr * rt_yr;
    rs   = {radius, 5'b00000};
    rssq = rs * rs;
  end

  // Latitude stage 2: saturation test and horizontal radius squared
  logic                    l2_v_q, l2_on_q, l2_sat_q, l2_ypos_q;
  logic signed [ROT_W-1:0] l2_xr_q, l2_yr_q, l2_zr_q;
  logic [RAD_W-1:0]        l2_rad_q;
  logic                    sat_d;

  assign sat_d = (l1_yrsq_q >= YSQ_W'(l1_rssq_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_v_q <= 1'b0;
      l2_v_q <= 1'b0;
    end else if (en) begin
      l1_v_q <= rt_v;
      l2_v_q <= l1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_on_q   <= rt_on;
      l1_xr_q   <= rt_xr;
      l1_yr_q   <= rt_yr;
      l1_zr_q   <= rt_zr;
      l1_yrsq_q <= $unsigned(yrsq);
      l1_rssq_q <= rssq;
      l2_on_q   <= l1_on_q;
      l2_sat_q  <= sat_d;
      l2_ypos_q <= !l1_yr_q[ROT_W-1] && (l1_yr_q != '0);
      l2_xr_q   <= l1_xr_q;
      l2_yr_q   <= l1_yr_q;
      l2_zr_q   <= l1_zr_q;
      l2_rad_q  <= sat_d ? '0 : (l1_rssq_q - l1_yrsq_q[RAD_W-1:0]);
    end
  end

  // Horizontal radius at the rotated height
  logic                    hs_v;
  logic [ROOT_W-1:0]       hs_root;
  logic [LSIDE_W-1:0]      hs_side;
  logic                    hs_on, hs_sat, hs_ypos;
  logic signed [ROT_W-1:0] hs_xr, hs_yr, hs_zr;

  gptm_sqrt_pipe #(
    .IN_W   (RAD_W),
    .SIDE_W (LSIDE_W)
  ) u_hsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (l2_v_q),
    .rad_i   (l2_rad_q),
    .side_i  ({l2_on_q, l2_sat_q, l2_ypos_q, l2_xr_q, l2_yr_q, l2_zr_q}),
    .valid_o (hs_v),
    .root_o  (hs_root),
    .side_o  (hs_side)
  );

  assign {hs_on, hs_sat, hs_ypos, hs_xr, hs_yr, hs_zr} = hs_side;

  // Latitude and longitude angles side by side
  logic                    lat_v, lon_v;
  logic signed [ANG_W-1:0] lat_ang, lon_ang;
  logic                    lat_sat, lat_ypos, lon_on;

  gptm_cordic_pipe #(
    .SIDE_W (2)
  ) u_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hs_v),
    .y_i     (-hs_yr),
    .x_i     ($signed(ROT_W'(hs_root))),
    .side_i  ({hs_sat, hs_ypos}),
    .valid_o (lat_v),
    .ang_o   (lat_ang),
    .side_o  ({lat_sat, lat_ypos})
  );

  gptm_cordic_pipe #(
    .SIDE_W (1)
  ) u_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hs_v),
    .y_i     (hs_xr),
    .x_i     (-hs_zr),
    .side_i  (hs_on),
    .valid_o (lon_v),
    .ang_o   (lon_ang),
    .side_o  (lon_on)
  );

  // Post stage 1: scale angles by texture size
  logic                     p1_v_q, p1_on_q;
  logic signed [PROD_W-1:0] p1_col_q, p1_row_q;
  logic signed [ANG_W-1:0]  lat_f, row_base, col_base;
  logic signed [PROD_W-1:0] col_prod, row_prod;

  always_comb begin
    lat_f = lat_ang;
    if (lat_sat) begin
      lat_f = lat_ypos ? -QUARTER_TURN : QUARTER_TURN;
    end
    row_base = QUARTER_TURN - lat_f;
    col_base = lon_ang + HALF_TURN;
    col_prod = col_base * $signed({1'b0, cols_c});
    row_prod = row_base * $signed({1'b0, rows_c});
  end

  // Post stage 2: round, clamp, drop off-globe items to zero
  logic signed [PROD_W-1:0]        col_sum, row_sum;
  logic signed [PROD_W-24-1:0]     col_v;
  logic signed [PROD_W-23-1:0]     row_v;
  logic [DIM_W-1:0]                col_c, row_c;

  always_comb begin
    col_sum = p1_col_q + PROD_W'(HALF_TURN);
    row_sum = p1_row_q + PROD_W'(QUARTER_TURN);
    col_v   = col_sum[PROD_W-1:24];
    row_v   = row_sum[PROD_W-1:23];
    priority if (cols_c == '0 || col_v < 0) begin
      col_c = '0;
    end else if (col_v > $signed((PROD_W-24)'(cols_c - 1'b1))) begin
      col_c = cols_c - 1'b1;
    end else begin
      col_c = col_v[DIM_W-1:0];
    end
    priority if (rows_c == '0 || row_v < 0) begin
      row_c = '0;
    end else if (row_v > $signed((PROD_W-23)'(rows_c - 1'b1))) begin
      row_c = rows_c - 1'b1;
    end else begin
      row_c = row_v[DIM_W-1:0];
    end
  end

  logic             out_on_q;
  logic [PIX_W-1:0] out_col_q, out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q  <= lat_v & lon_v;
      out_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_on_q   <= lon_on;
      p1_col_q  <= col_prod;
      p1_row_q  <= row_prod;
      out_on_q  <= p1_on_q;
      out_col_q <= p1_on_q ? col_c[PIX_W-1:0] : '0;
      out_row_q <= p1_on_q ? row_c[PIX_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign on_globe_o  = out_on_q;
  assign tex_col_o   = out_col_q;
  assign tex_row_o   = out_row_q;

  // Both angle units run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni) lat_v == lon_v)
    else $error("angle units out of step");

  // A held result blocks new items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output held");

  // Off-globe items carry zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !on_globe_o |-> tex_col_o == '0 && tex_row_o == '0)
    else $error("off-globe item with nonzero coordinates");

  // Column stays inside the texture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cols_c != '0 |-> {1'b0, tex_col_o} < cols_c)
    else $error("texture column out of range");

endmodule

/* bench/tb_globe_checker.sv */
`timescale 1ns / 100ps

module tb_globe_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [gptm_pkg::PIX_W-1:0]  pixel_x_i,
  input  logic [gptm_pkg::PIX_W-1:0]  pixel_y_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        on_globe_i,
  input  logic [gptm_pkg::PIX_W-1:0]  tex_col_i,
  input  logic [gptm_pkg::PIX_W-1:0]  tex_row_i,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [gptm_pkg::CFG_W-1:0]  cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import gptm_pkg::*;

  typedef struct packed {
    logic             on_globe;
    logic [PIX_W-1:0] tex_col;
    logic [PIX_W-1:0] tex_row;
  } texel_t;

  longint unsigned view_size, tex_cols, tex_rows;
  longint          quat [4];
  texel_t          texel_q [$];

  localparam longint ARCTAN [22] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1
  };

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= root + bit_v) begin
        v -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(root);
  endfunction

  // atan2 in 2^-24 turn units by vectoring
  function automatic longint angle_of(longint y, longint x);
    longint base, acc, xs, ys;
    base = 0;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? 8388608 : -8388608;
      x = -x;
      y = -y;
    end
    x *= 256;
    y *= 256;
    for (int i = 0; i < 22; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; acc += ARCTAN[i];
      end else begin
        x -= ys; y += xs; acc -= ARCTAN[i];
      end
    end
    return base + acc;
  endfunction

  function automatic void hamilton(input longint a [4], input longint b [4],
                                   output longint r [4]);
    r[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    r[1] = a[1]*b[0] + a[0]*b[1] + a[2]*b[3] - a[3]*b[2];
    r[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
    r[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
  endfunction

  function automatic texel_t map_pixel(longint px, longint py);
    texel_t res;
    longint rad, x2, y2, disc, xr, yr, zr, rs, lat, lon, cols, rows, v;
    longint conj [4], pt [4], t [4], u [4];
    res = '0;
    rad = longint'(view_size > 4096 ? 4096 : view_size) / 2;
    x2 = 2 * (px - rad) + 1;
    y2 = 2 * (py - rad) + 1;
    disc = 4*rad*rad - x2*x2 - y2*y2;
    if (disc < 0) return res;
    conj[0] = quat[0];
    for (int k = 1; k < 4; k++) conj[k] = -quat[k];
    pt[0] = 0;
    pt[1] = x2 * 16;
    pt[2] = y2 * 16;
    pt[3] = -int_sqrt(disc * 256);
    hamilton(quat, pt, t);
    hamilton(t, conj, u);
    xr = floor_shift(u[1] + (64'sd1 << 27), 28);
    yr = floor_shift(u[2] + (64'sd1 << 27), 28);
    zr = floor_shift(u[3] + (64'sd1 << 27), 28);
    rs = 32 * rad;
    if (yr*yr >= rs*rs) lat = (yr > 0) ? -4194304 : 4194304;
    else lat = angle_of(-yr, int_sqrt(rs*rs - yr*yr));
    lon = angle_of(xr, -zr);
    cols = longint'(tex_cols > 4096 ? 4096 : tex_cols);
    rows = longint'(tex_rows > 4096 ? 4096 : tex_rows);
    res.on_globe = 1'b1;
    if (cols > 0) begin
      v = ((lon + 8388608) * cols + 8388608) >>> 24;
      if (v < 0) v = 0;
      if (v > cols - 1) v = cols - 1;
      res.tex_col = v[PIX_W-1:0];
    end
    if (rows > 0) begin
      v = ((4194304 - lat) * rows + 4194304) >>> 23;
      if (v < 0) v = 0;
      if (v > rows - 1) v = rows - 1;
      res.tex_row = v[PIX_W-1:0];
    end
    return res;
  endfunction

  assign pending_o = texel_q.size();

  // Track registers, predict accepted items, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    texel_t got, want;
    if (!rst_ni) begin
      view_size = 512;
      quat = '{16384, 0, 0, 0};
      tex_cols = 2048;
      tex_rows = 1024;
      texel_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_IMAGE_SIZE: view_size = cfg_wdata_i[DIM_W-1:0];
          REG_ROT_W:      quat[0] = longint'($signed(cfg_wdata_i));
          REG_ROT_I:      quat[1] = longint'($signed(cfg_wdata_i));
          REG_ROT_J:      quat[2] = longint'($signed(cfg_wdata_i));
          REG_ROT_K:      quat[3] = longint'($signed(cfg_wdata_i));
          REG_TEX_COLS:   tex_cols = cfg_wdata_i[DIM_W-1:0];
          REG_TEX_ROWS:   tex_rows = cfg_wdata_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        texel_q.push_back(map_pixel(longint'(pixel_x_i), longint'(pixel_y_i)));
      if (out_valid_i && !out_stall_i) begin
        got = '{on_globe_i, tex_col_i, tex_row_i};
        if (texel_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %p", got);
        end else begin
          want = texel_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected on=%0d col=%0d row=%0d, got on=%0d col=%0d row=%0d",
                       want.on_globe, want.tex_col, want.tex_row,
                       got.on_globe, got.tex_col, got.tex_row);
          end
        end
      end
    end
  end
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import gptm_pkg::*;

  localparam int LATENCY = 69;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid, in_stall, out_valid, out_stall, on_globe;
  logic [PIX_W-1:0] pixel_x, pixel_y, tex_col, tex_row;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  int fail_count, pending, idle_cycles;
  bit quiet_tail, hold_long, sending_done;
  int unsigned cur_size;

  always #1 clk_i = ~clk_i;

  globe_pixel_to_texture_map DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pixel_x_i(pixel_x), .pixel_y_i(pixel_y),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .on_globe_o(on_globe), .tex_col_o(tex_col), .tex_row_o(tex_row),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  tb_globe_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .pixel_x_i(pixel_x), .pixel_y_i(pixel_y),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .on_globe_i(on_globe), .tex_col_i(tex_col), .tex_row_i(tex_row),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    in_valid = 0; pixel_x = 0; pixel_y = 0; out_stall = 0;
    cfg_we = 0; cfg_idx = REG_IMAGE_SIZE; cfg_wdata = 0;
  end

  // Write one register on a single cycle, then drop the write enable again
  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_SIZE) cur_size = val;
    @(negedge clk_i);
  endtask

  // Offer one item, with an optional random gap first
  task automatic send_pixel(int px, int py, bit gaps);
    if (gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    pixel_x <= px[PIX_W-1:0];
    pixel_y <= py[PIX_W-1:0];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic load_rotation(int w, int i, int j, int k);
    write_reg(REG_ROT_W, w);
    write_reg(REG_ROT_I, i);
    write_reg(REG_ROT_J, j);
    write_reg(REG_ROT_K, k);
  endtask

  // Random pixel mostly inside the view, sometimes anywhere
  task automatic random_burst(int count);
    int lim;
    for (int n = 0; n < count; n++) begin
      lim = (cur_size > 1 && cur_size <= 4096) ? cur_size - 1 : 4095;
      if ($urandom_range(0, 9) == 0)
        send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 1);
      else
        send_pixel($urandom_range(0, lim), $urandom_range(0, lim), 1);
    end
  endtask

  // Receiver stalls in bursts, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_long) begin
      out_stall <= 1'b1;
      repeat (300) @(negedge clk_i);
      hold_long = 0;
      out_stall <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    cur_size = 512;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset registers, corners, center, far field
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 0);
    send_pixel(256, 256, 0);
    send_pixel(511, 256, 0);
    send_pixel(256, 0, 0);
    send_pixel(256, 511, 0);
    send_pixel(0, 256, 0);
    send_pixel(4095, 4095, 0);
    send_pixel(200, 300, 0);
    drain();

    // Extreme sizes and full dimensions
    write_reg(REG_IMAGE_SIZE, 4096);
    write_reg(REG_TEX_COLS, 4096);
    write_reg(REG_TEX_ROWS, 4096);
    send_pixel(2048, 2048, 0);
    send_pixel(4095, 2048, 0);
    send_pixel(2048, 0, 0);
    send_pixel(0, 2047, 0);
    send_pixel(4095, 4095, 0);
    drain();
    write_reg(REG_IMAGE_SIZE, 8191);
    write_reg(REG_TEX_COLS, 8191);
    write_reg(REG_TEX_ROWS, 0);
    send_pixel(2048, 1000, 0);
    send_pixel(100, 2048, 0);
    drain();
    write_reg(REG_IMAGE_SIZE, 1);
    send_pixel(0, 0, 0);
    drain();
    write_reg(REG_IMAGE_SIZE, 2);
    write_reg(REG_TEX_COLS, 1);
    write_reg(REG_TEX_ROWS, 1);
    send_pixel(0, 0, 0);
    send_pixel(1, 1, 0);
    drain();

    // Non-unit quaternions, saturated latitude
    write_reg(REG_IMAGE_SIZE, 64);
    write_reg(REG_TEX_COLS, 360);
    write_reg(REG_TEX_ROWS, 180);
    load_rotation(16384, 16384, 16384, 16384);
    send_pixel(32, 32, 0);
    send_pixel(10, 40, 0);
    drain();
    load_rotation(-16384, -16384, -16384, -16384);
    send_pixel(32, 5, 0);
    drain();
    load_rotation(0, 0, 0, 0);
    send_pixel(31, 31, 0);
    drain();

    // Random phases over varied settings; one long receiver hold
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_IMAGE_SIZE, (ph % 4 == 3) ? $urandom_range(2, 8191)
                                              : $urandom_range(2, 300));
      load_rotation($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
      write_reg(REG_TEX_COLS, $urandom_range(0, 8191));
      write_reg(REG_TEX_ROWS, $urandom_range(0, 8191));
      if (ph == 3) hold_long = 1;
      if (ph == 11) quiet_tail = 1;
      random_burst(125);
      drain();
    end

    // Random pixels over the full pixel fields at the largest view
    write_reg(REG_IMAGE_SIZE, 4096);
    load_rotation(16384, 0, 0, 0);
    random_burst(30);
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/gptm_pkg.sv
rtl/core/gptm_sqrt_pipe.sv
rtl/core/gptm_rotate.sv
rtl/core/gptm_cordic_pipe.sv
rtl/core/globe_pixel_to_texture_map.sv
bench/tb_globe_checker.sv
bench/tb_top.sv
